// ----- rtl/tccw_pkg.sv -----
// ----------------------------------------------------------------------------
// tccw_pkg: shared types and constants of the text console cursor writer
// Field widths, character codes and the step unit's operation codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tccw_pkg;

    // fixed field widths
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 8;
    localparam int CELL_W  = CHAR_W + COLOR_W;
    localparam int CNT_W   = 5;   // holds up to the largest tab run (16)

    // character codes
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

    localparam logic [COLOR_W-1:0] COLOR_RESET = 8'd15;

    // operations of the shared step unit
    typedef enum logic [1:0] {
        OP_COL_INC,
        OP_COL_DEC,
        OP_ROW_INC,
        OP_ROW_DEC
    } t_step_op;

    // step unit result: new coordinate and edge hit
    typedef struct packed {
        logic [COL_W-1:0] value;
        logic             hit;
    } t_step_res;

endpackage

`default_nettype wire

// ----- rtl/tccw_step_unit.sv -----
// ----------------------------------------------------------------------------
// tccw_step_unit: shared cursor step adder
// One increment/decrement adder moves the cursor column or row and flags
// the right edge or the bottom wrap. Also gives the tab run length.
// ----------------------------------------------------------------------------
`default_nettype none

module tccw_step_unit
    import tccw_pkg::*;
#(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25,
    parameter int TAB_STOP       = 4
) (
    input  t_step_op               i_op,
    input  logic [ROW_W-1:0]       i_row,
    input  logic [COL_W-1:0]       i_col,
    output t_step_res              o_res,
    output logic [CNT_W-1:0]       o_tab_spaces
);

    // reciprocal of the tab stop; exact for any 7-bit column and stops up to 16
    localparam int RECIP_SH = 12;
    localparam int RECIP_M  = ((1 << RECIP_SH) + TAB_STOP - 1) / TAB_STOP;
    localparam int PROD_W   = COL_W + RECIP_SH;

    logic              w_is_row;
    logic              w_is_dec;
    logic [COL_W-1:0]  w_operand;
    logic [COL_W-1:0]  w_sum;
    logic [PROD_W-1:0] w_prod;
    logic [COL_W-1:0]  w_quot;
    logic [COL_W-1:0]  w_quot_mul;
    logic [COL_W-1:0]  w_rem;

    // decode the operation
    always_comb begin
        unique case (i_op)
            OP_COL_INC: begin w_is_row = 1'b0; w_is_dec = 1'b0; end
            OP_COL_DEC: begin w_is_row = 1'b0; w_is_dec = 1'b1; end
            OP_ROW_INC: begin w_is_row = 1'b1; w_is_dec = 1'b0; end
            OP_ROW_DEC: begin w_is_row = 1'b1; w_is_dec = 1'b1; end
            default:    begin w_is_row = 1'b0; w_is_dec = 1'b0; end
        endcase
    end

    // the one adder
    assign w_operand = w_is_row ? COL_W'(i_row) : i_col;
    assign w_sum     = w_operand + (w_is_dec ? {COL_W{1'b1}} : COL_W'(1));

    // edge detect; the row wraps to 0 past the last row
    always_comb begin
        o_res.hit   = 1'b0;
        o_res.value = w_sum;
        if (!w_is_dec) begin
            if (w_is_row) begin
                o_res.hit = (w_sum == COL_W'(SCREEN_ROWS));
                if (o_res.hit) o_res.value = '0;
            end else begin
                o_res.hit = (w_sum == COL_W'(SCREEN_COLUMNS));
            end
        end
    end

    // column mod tab stop: quotient by reciprocal multiply, then one subtract
    assign w_prod     = PROD_W'(i_col) * PROD_W'(RECIP_M);
    assign w_quot     = w_prod[PROD_W-1:RECIP_SH];
    assign w_quot_mul = w_quot * COL_W'(TAB_STOP);
    assign w_rem      = i_col - w_quot_mul;

    assign o_tab_spaces = CNT_W'(TAB_STOP) - w_rem[CNT_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/text_console_cursor_writer.sv -----
// Printable byte: S_PRINT loads the cell beat once the output slot is free;
// ready again in S_IDLE, after S_CLEAR on a wrap. Tab: one space per cycle
// while the output is not held (up to TAB_STOP), plus S_CLEAR per wrap.
// Newline: S_CLEAR, no write. Backspace: S_BACK. A held output beat stalls the
// sequencer. Reset (synchronous, active low): cursor 0,0, row ends 0, color 15.
// ----------------------------------------------------------------------------
// text_console_cursor_writer: character stream to text-screen cell writes
// Sequencer around a shared step unit; keeps cursor and per-row text end.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_writer
    import tccw_pkg::*;
#(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25,
    parameter int TAB_STOP       = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration write
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [COLOR_W-1:0] i_cfg_text_color,
    // character input
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [CHAR_W-1:0]  i_character,
    // cell write output
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [ROW_W-1:0]        o_cell_row,
    output logic [COL_W-1:0]        o_cell_column,
    output logic [CELL_W-1:0]       o_cell_value,
    output logic                    o_last_write
);

    localparam int RIDX_W = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PRINT,
        S_CLEAR,
        S_BACK
    } t_state;

    t_state             r_state;
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   r_col;
    logic [COL_W-1:0]   r_row_end [SCREEN_ROWS];
    logic [CNT_W-1:0]   r_count;
    logic [CHAR_W-1:0]  r_char;
    logic [COLOR_W-1:0] r_color;
    logic               r_out_valid;
    logic [ROW_W-1:0]   r_out_row;
    logic [COL_W-1:0]   r_out_col;
    logic [CELL_W-1:0]  r_out_value;
    logic               r_out_last;

    t_step_op           w_op;
    t_step_res          w_res;
    logic [CNT_W-1:0]   w_tab_spaces;
    logic [ROW_W-1:0]   w_res_row;
    logic [COL_W-1:0]   w_prev_end;
    logic               w_in_take;
    logic               w_slot_free;
    logic               w_out_load;

    // handshakes
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_take   = i_in_valid && !o_in_stall;
    assign w_slot_free = !r_out_valid || !i_out_stall;

    // a new cell beat enters the output register this cycle
    assign w_out_load  = w_slot_free &&
                         ((r_state == S_PRINT) || (r_state == S_BACK && r_col != '0));

    // choose the step for this cycle
    always_comb begin
        unique case (r_state)
            S_IDLE:  w_op = OP_COL_INC;
            S_PRINT: w_op = OP_COL_INC;
            S_CLEAR: w_op = OP_ROW_INC;
            S_BACK:  w_op = (r_col == '0) ? OP_ROW_DEC : OP_COL_DEC;
            default: w_op = OP_COL_INC;
        endcase
    end

    tccw_step_unit #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_ROWS    (SCREEN_ROWS),
        .TAB_STOP       (TAB_STOP)
    ) u_step (
        .i_op         (w_op),
        .i_row        (r_row),
        .i_col        (r_col),
        .o_res        (w_res),
        .o_tab_spaces (w_tab_spaces)
    );

    assign w_res_row  = w_res.value[ROW_W-1:0];
    assign w_prev_end = r_row_end[w_res_row[RIDX_W-1:0]];

    // sequencer, cursor, row ends and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row       <= '0;
            r_col       <= '0;
            r_count     <= '0;
            r_color     <= COLOR_RESET;
            r_out_valid <= 1'b0;
            for (int i = 0; i < SCREEN_ROWS; i++) r_row_end[i] <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) r_color <= i_cfg_text_color;
            r_out_valid <= w_out_load || (r_out_valid && i_out_stall);

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_take) begin
                        priority case (i_character)
                            CH_TAB: begin
                                r_count <= w_tab_spaces;
                                r_char  <= CH_SPACE;
                                r_state <= S_PRINT;
                            end
                            CH_NEWLINE: begin
                                r_row_end[r_row[RIDX_W-1:0]] <= r_col;
                                r_count <= '0;
                                r_state <= S_CLEAR;
                            end
                            CH_BACKSPACE: begin
                                r_state <= S_BACK;
                            end
                            default: begin
                                r_count <= CNT_W'(1);
                                r_char  <= i_character;
                                r_state <= S_PRINT;
                            end
                        endcase
                    end
                end

                // one cell write per beat, wrap handled in S_CLEAR
                S_PRINT: begin
                    if (w_slot_free) begin
                        r_out_row   <= r_row;
                        r_out_col   <= r_col;
                        r_out_value <= {r_color, r_char};
                        r_out_last  <= (r_count == CNT_W'(1));
                        r_count     <= r_count - CNT_W'(1);
                        if (w_res.hit) begin
                            r_row_end[r_row[RIDX_W-1:0]] <= COL_W'(SCREEN_COLUMNS);
                            r_state <= S_CLEAR;
                        end else begin
                            r_col   <= w_res.value;
                            r_state <= (r_count == CNT_W'(1)) ? S_IDLE : S_PRINT;
                        end
                    end
                end

                // move to column 0 of the next row and clear its text end
                S_CLEAR: begin
                    r_row <= w_res_row;
                    r_col <= '0;
                    r_row_end[w_res_row[RIDX_W-1:0]] <= '0;
                    r_state <= (r_count != '0) ? S_PRINT : S_IDLE;
                end

                S_BACK: begin
                    if (r_col == '0) begin
                        // step up to the end of the previous row
                        if (r_row == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_row <= w_res_row;
                            r_col <= w_prev_end;
                            if (w_prev_end == '0) r_state <= S_IDLE;
                        end
                    end else if (w_slot_free) begin
                        // erase the previous cell
                        r_out_row   <= r_row;
                        r_out_col   <= w_res.value;
                        r_out_value <= {r_color, CH_SPACE};
                        r_out_last  <= 1'b1;
                        r_col       <= w_res.value;
                        r_row_end[r_row[RIDX_W-1:0]] <= w_res.value;
                        r_state     <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_cell_row    = r_out_row;
    assign o_cell_column = r_out_col;
    assign o_cell_value  = r_out_value;
    assign o_last_write  = r_out_last;

endmodule

`default_nettype wire
